@@ design/class_file_stream_parser_defines.svh @@
// ----------------------------------------------------------------------------
// class_file_stream_parser_defines
// assertion macros used by the class file stream parser walker module
// ----------------------------------------------------------------------------
`ifndef CLASS_FILE_STREAM_PARSER_DEFINES_SVH
`define CLASS_FILE_STREAM_PARSER_DEFINES_SVH

// same-cycle implication
`define CFSP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cfsp assertion failed");

// next-cycle implication
`define CFSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cfsp assertion failed");

`endif

@@ design/cfsp_pkg.sv @@
// ----------------------------------------------------------------------------
// cfsp_pkg
// types, phase codes, token kinds and field tables of the class file parser
// ----------------------------------------------------------------------------
package cfsp_pkg;

    localparam logic [4:0] PH_MAGIC   = 5'd0;
    localparam logic [4:0] PH_MINOR   = 5'd1;
    localparam logic [4:0] PH_MAJOR   = 5'd2;
    localparam logic [4:0] PH_CPCOUNT = 5'd3;
    localparam logic [4:0] PH_CPTAG   = 5'd4;
    localparam logic [4:0] PH_UTFLEN  = 5'd5;
    localparam logic [4:0] PH_CPDATA  = 5'd6;
    localparam logic [4:0] PH_ACCESS  = 5'd7;
    localparam logic [4:0] PH_THIS    = 5'd8;
    localparam logic [4:0] PH_SUPER   = 5'd9;
    localparam logic [4:0] PH_IFCOUNT = 5'd10;
    localparam logic [4:0] PH_IFENTRY = 5'd11;
    localparam logic [4:0] PH_FCOUNT  = 5'd12;
    localparam logic [4:0] PH_MACCESS = 5'd13;
    localparam logic [4:0] PH_MNAME   = 5'd14;
    localparam logic [4:0] PH_MDESC   = 5'd15;
    localparam logic [4:0] PH_MACOUNT = 5'd16;
    localparam logic [4:0] PH_ANAME   = 5'd17;
    localparam logic [4:0] PH_ALEN    = 5'd18;
    localparam logic [4:0] PH_ADATA   = 5'd19;
    localparam logic [4:0] PH_MCOUNT  = 5'd20;
    localparam logic [4:0] PH_CACOUNT = 5'd21;
    localparam logic [4:0] PH_DONE    = 5'd22;

    localparam logic [4:0] TK_NONE      = 5'd0;
    localparam logic [4:0] TK_MAGIC     = 5'd1;
    localparam logic [4:0] TK_MINOR     = 5'd2;
    localparam logic [4:0] TK_MAJOR     = 5'd3;
    localparam logic [4:0] TK_CPCOUNT   = 5'd4;
    localparam logic [4:0] TK_CPTAG     = 5'd5;
    localparam logic [4:0] TK_UTFLEN    = 5'd6;
    localparam logic [4:0] TK_CPBYTE    = 5'd7;
    localparam logic [4:0] TK_ACCESS    = 5'd8;
    localparam logic [4:0] TK_THIS      = 5'd9;
    localparam logic [4:0] TK_SUPER     = 5'd10;
    localparam logic [4:0] TK_IFCOUNT   = 5'd11;
    localparam logic [4:0] TK_IFENTRY   = 5'd12;
    localparam logic [4:0] TK_FCOUNT    = 5'd13;
    localparam logic [4:0] TK_MACCESS   = 5'd14;
    localparam logic [4:0] TK_MNAME     = 5'd15;
    localparam logic [4:0] TK_MDESC     = 5'd16;
    localparam logic [4:0] TK_ACOUNT    = 5'd17;
    localparam logic [4:0] TK_ANAME     = 5'd18;
    localparam logic [4:0] TK_ALEN      = 5'd19;
    localparam logic [4:0] TK_ABYTE     = 5'd20;
    localparam logic [4:0] TK_MCOUNT    = 5'd21;
    localparam logic [4:0] TK_DONE      = 5'd22;

    localparam logic [2:0] SEC_HEADER  = 3'd0;
    localparam logic [2:0] SEC_POOL    = 3'd1;
    localparam logic [2:0] SEC_FIELDS  = 3'd2;
    localparam logic [2:0] SEC_METHODS = 3'd3;
    localparam logic [2:0] SEC_CLASS   = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_TAG  = 2'd1;
    localparam logic [1:0] ST_TRUNC    = 2'd2;
    localparam logic [1:0] ST_TRAILING = 2'd3;

    localparam logic [7:0] TAG_UTF8 = 8'd1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_item;

    typedef struct packed {
        logic [4:0]  token_kind;
        logic [31:0] token_value;
        logic [2:0]  section;
        logic [15:0] item_index;
        logic [1:0]  status;
    } t_result;

    function automatic logic [2:0] phase_width(input logic [4:0] phase);
        logic [2:0] w;
        case (phase)
            PH_MAGIC, PH_ALEN:               w = 3'd4;
            PH_CPTAG, PH_CPDATA, PH_ADATA:   w = 3'd1;
            default:                         w = 3'd2;
        endcase
        if (phase == PH_DONE) begin
            w = 3'd1;
        end
        return w;
    endfunction

    // payload length of a pool tag, zero for unknown tags and for utf8
    function automatic logic [3:0] tag_length(input logic [7:0] tag);
        logic [3:0] len;
        case (tag)
            8'd3, 8'd4, 8'd9, 8'd10, 8'd11, 8'd12, 8'd18: len = 4'd4;
            8'd15:                                        len = 4'd3;
            8'd7, 8'd8, 8'd16:                            len = 4'd2;
            8'd5, 8'd6:                                   len = 4'd8;
            default:                                      len = 4'd0;
        endcase
        return len;
    endfunction

endpackage

@@ design/class_file_stream_parser.sv @@
// a byte is walked from the input register and its token loaded into the output register
// one byte per cycle unless stalled; the single-pass walker updates all state per byte
// a byte that completes no field yields no output transaction unless it raises an error
// reset: synchronous active-low, clears phase, counters, accumulator and valids
// ----------------------------------------------------------------------------
// class_file_stream_parser
// streaming class file parser, emits one typed token per completed field
// ----------------------------------------------------------------------------
module class_file_stream_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_stream,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [4:0]  o_token_kind,
    output logic [31:0] o_token_value,
    output logic [2:0]  o_section,
    output logic [15:0] o_item_index,
    output logic [1:0]  o_status
);
    import cfsp_pkg::*;

    t_item   item;
    logic    item_valid;
    logic    out_free;
    logic    proc;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign proc = item_valid && out_free;

    cfsp_input_stage u_input (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_data_byte     (i_data_byte),
        .i_end_of_stream (i_end_of_stream),
        .o_in_stall      (o_in_stall),
        .i_take          (proc),
        .o_valid         (item_valid),
        .o_item          (item)
    );

    cfsp_walker u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_proc      (proc),
        .i_item      (item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    cfsp_output_stage u_output (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (proc && res_valid),
        .i_res       (res),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_res       (out_res)
    );

    assign o_token_kind  = out_res.token_kind;
    assign o_token_value = out_res.token_value;
    assign o_section     = out_res.section;
    assign o_item_index  = out_res.item_index;
    assign o_status      = out_res.status;

endmodule

@@ design/cfsp_input_stage.sv @@
// ----------------------------------------------------------------------------
// cfsp_input_stage
// input register of the byte stream, holds one transaction until walked
// ----------------------------------------------------------------------------
module cfsp_input_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic [7:0]     i_data_byte,
    input  logic           i_end_of_stream,
    output logic           o_in_stall,
    input  logic           i_take,
    output logic           o_valid,
    output cfsp_pkg::t_item o_item
);
    import cfsp_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  load_en;

    assign load_en    = !r_valid || i_take;
    assign o_in_stall = !load_en;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load_en) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_en && i_in_valid) begin
            r_item.data_byte     <= i_data_byte;
            r_item.end_of_stream <= i_end_of_stream;
        end
    end

endmodule

@@ design/cfsp_walker.sv @@
// ----------------------------------------------------------------------------
// cfsp_walker
// structure walker: phase, counters, field accumulator; a byte per i_proc cycle
// ----------------------------------------------------------------------------
`include "class_file_stream_parser_defines.svh"

module cfsp_walker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_proc,
    input  cfsp_pkg::t_item   i_item,
    output logic              o_res_valid,
    output cfsp_pkg::t_result o_res
);
    import cfsp_pkg::*;

    logic [4:0]  r_phase,        n_phase;
    logic [1:0]  r_bif,          n_bif;
    logic [31:0] r_acc,          n_acc;
    logic [15:0] r_pool_left,    n_pool_left;
    logic [15:0] r_entries_left, n_entries_left;
    logic [15:0] r_attr_left,    n_attr_left;
    logic [31:0] r_payload_left, n_payload_left;
    logic [15:0] r_entry_cnt,    n_entry_cnt;
    logic        r_stopped,      n_stopped;
    logic [2:0]  r_section,      n_section;
    logic        r_wide,         n_wide;

    logic [31:0] acc;
    logic [2:0]  cnt;
    logic [31:0] value;
    logic [4:0]  kind;
    logic [1:0]  status;
    logic        emit;
    logic [15:0] ent_dec;
    logic [15:0] attr_dec;
    logic [31:0] pay_dec;
    logic [7:0]  tag;
    logic [3:0]  tag_len;
    logic        do_pool_next;
    logic        do_member_next;
    logic        do_attr_next;

    assign acc      = {r_acc[23:0], i_item.data_byte};
    assign cnt      = {1'b0, r_bif} + 3'd1;
    assign ent_dec  = r_entries_left - 16'd1;
    assign attr_dec = r_attr_left - 16'd1;
    assign pay_dec  = r_payload_left - 32'd1;
    assign tag      = acc[7:0];
    assign tag_len  = tag_length(tag);

    always_comb begin
        n_phase        = r_phase;
        n_bif          = r_bif;
        n_acc          = r_acc;
        n_pool_left    = r_pool_left;
        n_entries_left = r_entries_left;
        n_attr_left    = r_attr_left;
        n_payload_left = r_payload_left;
        n_entry_cnt    = r_entry_cnt;
        n_stopped      = r_stopped;
        n_section      = r_section;
        n_wide         = r_wide;
        value          = 32'd0;
        kind           = TK_NONE;
        status         = ST_OK;
        emit           = 1'b0;
        do_pool_next   = 1'b0;
        do_member_next = 1'b0;
        do_attr_next   = 1'b0;

        if (!r_stopped) begin
            if (r_phase >= PH_DONE) begin
                status = ST_TRAILING;
            end else if (cnt < phase_width(r_phase)) begin
                n_bif = cnt[1:0];
                n_acc = acc;
            end else begin
                n_bif = 2'd0;
                n_acc = 32'd0;
                value = acc;
                emit  = 1'b1;
                case (r_phase)
                    PH_MAGIC: begin
                        kind    = TK_MAGIC;
                        n_phase = PH_MINOR;
                    end
                    PH_MINOR: begin
                        kind    = TK_MINOR;
                        n_phase = PH_MAJOR;
                    end
                    PH_MAJOR: begin
                        kind        = TK_MAJOR;
                        n_phase     = PH_CPCOUNT;
                        n_section   = SEC_POOL;
                        n_entry_cnt = 16'd0;
                    end
                    PH_CPCOUNT: begin
                        kind        = TK_CPCOUNT;
                        n_pool_left = (acc[15:0] != 16'd0) ? acc[15:0] - 16'd1 : 16'd0;
                        if (acc[15:0] <= 16'd1) begin
                            n_phase     = PH_ACCESS;
                            n_section   = SEC_HEADER;
                            n_entry_cnt = 16'd0;
                        end else begin
                            n_phase     = PH_CPTAG;
                            n_entry_cnt = 16'd1;
                        end
                    end
                    PH_CPTAG: begin
                        kind = TK_CPTAG;
                        if (tag != TAG_UTF8 && tag_len == 4'd0) begin
                            status = ST_BAD_TAG;
                        end else begin
                            n_wide = (tag_len == 4'd8);
                            if (tag_len == 4'd8 && r_pool_left >= 16'd2) begin
                                n_pool_left = r_pool_left - 16'd2;
                            end else if (r_pool_left != 16'd0) begin
                                n_pool_left = r_pool_left - 16'd1;
                            end
                            if (tag == TAG_UTF8) begin
                                n_phase = PH_UTFLEN;
                            end else begin
                                n_payload_left = {28'd0, tag_len};
                                n_phase        = PH_CPDATA;
                            end
                        end
                    end
                    PH_UTFLEN: begin
                        kind           = TK_UTFLEN;
                        n_payload_left = {16'd0, acc[15:0]};
                        if (acc[15:0] == 16'd0) begin
                            do_pool_next = 1'b1;
                        end else begin
                            n_phase = PH_CPDATA;
                        end
                    end
                    PH_CPDATA: begin
                        kind           = TK_CPBYTE;
                        n_payload_left = pay_dec;
                        do_pool_next   = (pay_dec == 32'd0);
                    end
                    PH_ACCESS: begin
                        kind    = TK_ACCESS;
                        n_phase = PH_THIS;
                    end
                    PH_THIS: begin
                        kind    = TK_THIS;
                        n_phase = PH_SUPER;
                    end
                    PH_SUPER: begin
                        kind    = TK_SUPER;
                        n_phase = PH_IFCOUNT;
                    end
                    PH_IFCOUNT: begin
                        kind           = TK_IFCOUNT;
                        n_entries_left = acc[15:0];
                        if (acc[15:0] == 16'd0) begin
                            n_phase     = PH_FCOUNT;
                            n_section   = SEC_FIELDS;
                            n_entry_cnt = 16'd0;
                        end else begin
                            n_phase = PH_IFENTRY;
                        end
                    end
                    PH_IFENTRY: begin
                        kind           = TK_IFENTRY;
                        n_entry_cnt    = r_entry_cnt + 16'd1;
                        n_entries_left = ent_dec;
                        if (ent_dec == 16'd0) begin
                            n_phase     = PH_FCOUNT;
                            n_section   = SEC_FIELDS;
                            n_entry_cnt = 16'd0;
                        end
                    end
                    PH_FCOUNT: begin
                        kind           = TK_FCOUNT;
                        n_entries_left = acc[15:0];
                        if (acc[15:0] == 16'd0) begin
                            n_phase     = PH_MCOUNT;
                            n_section   = SEC_METHODS;
                            n_entry_cnt = 16'd0;
                        end else begin
                            n_phase = PH_MACCESS;
                        end
                    end
                    PH_MACCESS: begin
                        kind    = TK_MACCESS;
                        n_phase = PH_MNAME;
                    end
                    PH_MNAME: begin
                        kind    = TK_MNAME;
                        n_phase = PH_MDESC;
                    end
                    PH_MDESC: begin
                        kind    = TK_MDESC;
                        n_phase = PH_MACOUNT;
                    end
                    PH_MACOUNT: begin
                        kind        = TK_ACOUNT;
                        n_attr_left = acc[15:0];
                        if (acc[15:0] == 16'd0) begin
                            do_member_next = 1'b1;
                        end else begin
                            n_phase = PH_ANAME;
                        end
                    end
                    PH_ANAME: begin
                        kind    = TK_ANAME;
                        n_phase = PH_ALEN;
                    end
                    PH_ALEN: begin
                        kind           = TK_ALEN;
                        n_payload_left = acc;
                        if (acc == 32'd0) begin
                            do_attr_next = 1'b1;
                        end else begin
                            n_phase = PH_ADATA;
                        end
                    end
                    PH_ADATA: begin
                        kind           = TK_ABYTE;
                        n_payload_left = pay_dec;
                        do_attr_next   = (pay_dec == 32'd0);
                    end
                    PH_MCOUNT: begin
                        kind           = TK_MCOUNT;
                        n_entries_left = acc[15:0];
                        if (acc[15:0] == 16'd0) begin
                            n_phase     = PH_CACOUNT;
                            n_section   = SEC_CLASS;
                            n_entry_cnt = 16'd0;
                        end else begin
                            n_phase = PH_MACCESS;
                        end
                    end
                    PH_CACOUNT: begin
                        kind        = TK_ACOUNT;
                        n_attr_left = acc[15:0];
                        n_phase     = (acc[15:0] == 16'd0) ? PH_DONE : PH_ANAME;
                    end
                    default: begin
                        kind = TK_NONE;
                    end
                endcase

                if (do_attr_next) begin
                    n_attr_left = attr_dec;
                    if (r_section == SEC_CLASS) begin
                        n_entry_cnt = r_entry_cnt + 16'd1;
                    end
                    if (attr_dec != 16'd0) begin
                        n_phase = PH_ANAME;
                    end else if (r_section == SEC_CLASS) begin
                        n_phase = PH_DONE;
                    end else begin
                        do_member_next = 1'b1;
                    end
                end

                if (do_member_next) begin
                    n_entry_cnt    = r_entry_cnt + 16'd1;
                    n_entries_left = ent_dec;
                    if (ent_dec != 16'd0) begin
                        n_phase = PH_MACCESS;
                    end else if (r_section == SEC_FIELDS) begin
                        n_phase     = PH_MCOUNT;
                        n_section   = SEC_METHODS;
                        n_entry_cnt = 16'd0;
                    end else begin
                        n_phase     = PH_CACOUNT;
                        n_section   = SEC_CLASS;
                        n_entry_cnt = 16'd0;
                    end
                end

                if (do_pool_next) begin
                    n_entry_cnt = r_entry_cnt + (r_wide ? 16'd2 : 16'd1);
                    n_wide      = 1'b0;
                    if (r_pool_left == 16'd0) begin
                        n_phase     = PH_ACCESS;
                        n_section   = SEC_HEADER;
                        n_entry_cnt = 16'd0;
                    end else begin
                        n_phase = PH_CPTAG;
                    end
                end

                if (status == ST_OK && n_phase == PH_DONE) begin
                    kind = TK_DONE;
                end
            end

            if (r_phase < PH_DONE && status == ST_OK && i_item.end_of_stream
                && n_phase != PH_DONE) begin
                status = ST_TRUNC;
            end
        end

        if (status != ST_OK) begin
            n_stopped = 1'b1;
        end
    end

    assign o_res_valid       = emit || (status != ST_OK);
    assign o_res.token_kind  = kind;
    assign o_res.token_value = value;
    assign o_res.section     = r_section;
    assign o_res.item_index  = r_entry_cnt;
    assign o_res.status      = status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_MAGIC;
            r_bif          <= 2'd0;
            r_acc          <= 32'd0;
            r_pool_left    <= 16'd0;
            r_entries_left <= 16'd0;
            r_attr_left    <= 16'd0;
            r_payload_left <= 32'd0;
            r_entry_cnt    <= 16'd0;
            r_stopped      <= 1'b0;
            r_section      <= SEC_HEADER;
            r_wide         <= 1'b0;
        end else if (i_proc) begin
            r_phase        <= n_phase;
            r_bif          <= n_bif;
            r_acc          <= n_acc;
            r_pool_left    <= n_pool_left;
            r_entries_left <= n_entries_left;
            r_attr_left    <= n_attr_left;
            r_payload_left <= n_payload_left;
            r_entry_cnt    <= n_entry_cnt;
            r_stopped      <= n_stopped;
            r_section      <= n_section;
            r_wide         <= n_wide;
        end
    end

    `CFSP_ASSERT_NEXT(a_stop_sticky, i_clk, i_rst_n, r_stopped, r_stopped)
    `CFSP_ASSERT_NOW(a_stop_silent, i_clk, i_rst_n, r_stopped, !o_res_valid)
    `CFSP_ASSERT_NEXT(a_error_stops, i_clk, i_rst_n, i_proc && o_res.status != ST_OK, r_stopped)
    `CFSP_ASSERT_NOW(a_done_in_class, i_clk, i_rst_n,
        o_res_valid && o_res.token_kind == TK_DONE, r_section == SEC_CLASS)

endmodule

@@ design/cfsp_output_stage.sv @@
// ----------------------------------------------------------------------------
// cfsp_output_stage
// result register of the token stream, frees when the transaction is taken
// ----------------------------------------------------------------------------
module cfsp_output_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  cfsp_pkg::t_result i_res,
    output logic              o_free,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output cfsp_pkg::t_result o_res
);
    import cfsp_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free      = !r_valid || !i_out_stall;
    assign o_out_valid = r_valid;
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

endmodule
